>>> design/h2ft_pkg.sv
// ----------------------------------------------------------------------------
// h2ft_pkg: shared types and constants for the HTTP/2 response frame tracker
// Frame type codes, flag bits, verdict codes, register indexes and the
// records that travel between the front, the back and the queues.
// ----------------------------------------------------------------------------
package h2ft_pkg;

  localparam int LEN_W    = 24;
  localparam int TYPE_W   = 8;
  localparam int FLAGS_W  = 8;
  localparam int STREAM_W = 31;
  localparam int WORD_W   = 32;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 1;

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [STREAM_W-1:0] RESET_STREAM_ID  = 31'd1;
  localparam logic [LEN_W-1:0]    RESET_MAX_FRAME  = 24'd16384;
  localparam logic [WORD_W-1:0]   RESET_SEND_WIN   = 32'd65535;

  localparam int FLAG_END_STREAM  = 0;
  localparam int FLAG_END_HEADERS = 2;

  localparam logic [TYPE_W-1:0] TYPE_DATA          = 8'd0;
  localparam logic [TYPE_W-1:0] TYPE_HEADERS       = 8'd1;
  localparam logic [TYPE_W-1:0] TYPE_RST_STREAM    = 8'd3;
  localparam logic [TYPE_W-1:0] TYPE_PING          = 8'd6;
  localparam logic [TYPE_W-1:0] TYPE_GOAWAY        = 8'd7;
  localparam logic [TYPE_W-1:0] TYPE_WINDOW_UPDATE = 8'd8;
  localparam logic [TYPE_W-1:0] TYPE_CONTINUATION  = 8'd9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESPONSE_STREAM_ID = 1'b0,
    REG_MAX_FRAME_SIZE     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    V_CONTINUE   = 3'd0,
    V_DONE       = 3'd1,
    V_IGNORED    = 3'd2,
    V_OVERSIZE   = 3'd3,
    V_GOAWAY     = 3'd4,
    V_DATA_EARLY = 3'd5,
    V_RESET      = 3'd6
  } verdict_t;

  // what the front decided about a frame
  typedef enum logic [3:0] {
    CLS_OVERSIZE,
    CLS_GOAWAY,
    CLS_PING_REQ,
    CLS_WIN_UPDATE,
    CLS_CONN_OTHER,
    CLS_OTHER_STREAM,
    CLS_BLOCK,
    CLS_DATA,
    CLS_RST,
    CLS_RESP_OTHER
  } frame_class_t;

  typedef struct packed {
    frame_class_t      cls;
    logic              es_flag;
    logic              eh_flag;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] arg;   // window increment or reset code, zero if short
  } item_t;

  typedef struct packed {
    verdict_t          verdict;
    logic              ping_ack_needed;
    logic [LEN_W-1:0]  window_credit;
    logic              fragment_append;
    logic              block_complete;
    logic              block_is_trailer;
    logic [WORD_W-1:0] reset_code;
    logic [WORD_W-1:0] send_window;
  } result_t;

endpackage

>>> design/h2ft_fifo.sv
// ----------------------------------------------------------------------------
// h2ft_fifo: small synchronous queue
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module h2ft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/h2ft_front.sv
// ----------------------------------------------------------------------------
// h2ft_front: frame classifier
// Holds the configuration registers and sorts each frame header into a
// class for the back end, with its length and payload argument.
// ----------------------------------------------------------------------------
module h2ft_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [h2ft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [h2ft_pkg::CFG_W-1:0]    cfg_data,
  input  logic [h2ft_pkg::LEN_W-1:0]    frame_length,
  input  logic [h2ft_pkg::TYPE_W-1:0]   frame_type,
  input  logic [h2ft_pkg::FLAGS_W-1:0]  frame_flags,
  input  logic [h2ft_pkg::STREAM_W-1:0] frame_stream,
  input  logic [h2ft_pkg::WORD_W-1:0]   payload_word,
  output h2ft_pkg::item_t               item,
  output logic                          track_clear
);
  import h2ft_pkg::*;

  logic [STREAM_W-1:0] response_stream_id;
  logic [LEN_W-1:0]    max_frame_size;
  logic                long_enough;

  assign track_clear = cfg_write && (reg_idx_t'(cfg_index) == REG_RESPONSE_STREAM_ID);

  always_ff @(posedge clk) begin
    if (rst) begin
      response_stream_id <= RESET_STREAM_ID;
      max_frame_size     <= RESET_MAX_FRAME;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RESPONSE_STREAM_ID: response_stream_id <= cfg_data[STREAM_W-1:0];
        REG_MAX_FRAME_SIZE:     max_frame_size     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign long_enough = (frame_length >= LEN_W'(4));

  always_comb begin
    item.es_flag = frame_flags[FLAG_END_STREAM];
    item.eh_flag = frame_flags[FLAG_END_HEADERS];
    item.len     = frame_length;
    item.arg     = '0;
    item.cls     = CLS_RESP_OTHER;
    if (frame_length > max_frame_size) begin
      item.cls = CLS_OVERSIZE;
    end else if (frame_stream == '0) begin
      if (frame_type == TYPE_GOAWAY) begin
        item.cls = CLS_GOAWAY;
      end else if (frame_type == TYPE_PING && !frame_flags[FLAG_END_STREAM]) begin
        item.cls = CLS_PING_REQ;
      end else if (frame_type == TYPE_WINDOW_UPDATE) begin
        // reserved top bit dropped; a short frame adds nothing
        item.cls = CLS_WIN_UPDATE;
        item.arg = long_enough ? {1'b0, payload_word[WORD_W-2:0]} : '0;
      end else begin
        item.cls = CLS_CONN_OTHER;
      end
    end else if (frame_stream != response_stream_id) begin
      item.cls = CLS_OTHER_STREAM;
    end else if (frame_type == TYPE_HEADERS || frame_type == TYPE_CONTINUATION) begin
      item.cls = CLS_BLOCK;
    end else if (frame_type == TYPE_DATA) begin
      item.cls = CLS_DATA;
    end else if (frame_type == TYPE_RST_STREAM) begin
      item.cls = CLS_RST;
      item.arg = long_enough ? payload_word : '0;
    end
  end

endmodule

>>> design/h2ft_back.sv
// ----------------------------------------------------------------------------
// h2ft_back: response tracking engine
// Takes classified frames one per cycle while its input queue holds an item and
// the result queue has room, updates the header block flags and the connection
// send window, and builds the result item.
module h2ft_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                track_clear,
  input  logic                in_empty,
  input  h2ft_pkg::item_t     in_item,
  output logic                in_pop,
  input  logic                out_full,
  output logic                out_push,
  output h2ft_pkg::result_t   out_result
);
  import h2ft_pkg::*;

  logic              collecting_block, collecting_block_next;
  logic              headers_seen, headers_seen_next;
  logic              trailer_block, trailer_block_next;
  logic              response_done, response_done_next;
  logic [WORD_W-1:0] conn_send_window, conn_send_window_next;
  logic              fire;

  assign fire     = !in_empty && !out_full;
  assign in_pop   = fire;
  assign out_push = fire;

  always_comb begin
    collecting_block_next = collecting_block;
    headers_seen_next     = headers_seen;
    trailer_block_next    = trailer_block;
    response_done_next    = response_done;
    conn_send_window_next = conn_send_window;
    out_result            = '0;
    out_result.verdict    = V_CONTINUE;

    case (in_item.cls)
      CLS_OVERSIZE:     out_result.verdict = V_OVERSIZE;
      CLS_GOAWAY:       out_result.verdict = V_GOAWAY;
      CLS_PING_REQ:     out_result.ping_ack_needed = 1'b1;
      CLS_WIN_UPDATE:   conn_send_window_next = conn_send_window + in_item.arg;
      CLS_CONN_OTHER:   ;
      CLS_OTHER_STREAM: out_result.verdict = V_IGNORED;
      default: begin
        if (response_done) begin
          out_result.verdict = V_IGNORED;
        end else begin
          case (in_item.cls)
            CLS_BLOCK: begin
              if (!collecting_block) begin
                collecting_block_next = 1'b1;
                if (headers_seen) begin
                  trailer_block_next = 1'b1;
                end
              end
              out_result.fragment_append = 1'b1;
              if (in_item.eh_flag) begin
                out_result.block_complete   = 1'b1;
                out_result.block_is_trailer = trailer_block_next;
                collecting_block_next       = 1'b0;
                if (trailer_block_next) begin
                  trailer_block_next = 1'b0;
                end else begin
                  headers_seen_next = 1'b1;
                end
                if (in_item.es_flag) begin
                  response_done_next = 1'b1;
                end
              end
              out_result.verdict = response_done_next ? V_DONE : V_CONTINUE;
            end
            CLS_DATA: begin
              if (!collecting_block && !headers_seen) begin
                out_result.verdict = V_DATA_EARLY;
              end else begin
                out_result.window_credit = in_item.len;
                response_done_next       = in_item.es_flag;
                out_result.verdict       = in_item.es_flag ? V_DONE : V_CONTINUE;
              end
            end
            CLS_RST: begin
              out_result.verdict    = V_RESET;
              out_result.reset_code = in_item.arg;
            end
            default: ;
          endcase
        end
      end
    endcase

    out_result.send_window = conn_send_window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting_block <= 1'b0;
      headers_seen     <= 1'b0;
      trailer_block    <= 1'b0;
      response_done    <= 1'b0;
      conn_send_window <= RESET_SEND_WIN;
    end else if (track_clear) begin
      // the user must make the register write only while idle, so no item is in flight; the block does not enforce it
      collecting_block <= 1'b0;
      headers_seen     <= 1'b0;
      trailer_block    <= 1'b0;
      response_done    <= 1'b0;
    end else if (fire) begin
      collecting_block <= collecting_block_next;
      headers_seen     <= headers_seen_next;
      trailer_block    <= trailer_block_next;
      response_done    <= response_done_next;
      conn_send_window <= conn_send_window_next;
    end
  end

endmodule

>>> design/http2_response_frame_tracker_unit.sv
// ----------------------------------------------------------------------------
// http2_response_frame_tracker_unit: HTTP/2 response frame tracker
// Path: a frame is classified as it is pushed into the classifier queue; the engine
//   then pops it and pushes its result into the result queue, which drives the result ports.
// Throughput: one frame per cycle while the result queue is not full, set by the
//   engine's single flag update and window add per cycle.
// Reset: queues empty, tracking flags clear, send window 65535, registers
//   at their defaults (stream 1, max frame size 16384).
// ----------------------------------------------------------------------------
module http2_response_frame_tracker_unit #(
  parameter int QUEUE_DEPTH = h2ft_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [h2ft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [h2ft_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [h2ft_pkg::LEN_W-1:0]     frame_length,
  input  logic [h2ft_pkg::TYPE_W-1:0]    frame_type,
  input  logic [h2ft_pkg::FLAGS_W-1:0]   frame_flags,
  input  logic [h2ft_pkg::STREAM_W-1:0]  frame_stream,
  input  logic [h2ft_pkg::WORD_W-1:0]    payload_word,
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     verdict,
  output logic                           ping_ack_needed,
  output logic [h2ft_pkg::LEN_W-1:0]     window_credit,
  output logic                           fragment_append,
  output logic                           block_complete,
  output logic                           block_is_trailer,
  output logic [h2ft_pkg::WORD_W-1:0]    reset_code,
  output logic [h2ft_pkg::WORD_W-1:0]    send_window
);
  import h2ft_pkg::*;

  item_t   front_item;
  item_t   mid_item;
  logic    track_clear;
  logic    mid_empty;
  logic    mid_pop;
  logic    out_full;
  logic    out_push;
  result_t back_result;
  result_t head_result;

  h2ft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_length (frame_length),
    .frame_type   (frame_type),
    .frame_flags  (frame_flags),
    .frame_stream (frame_stream),
    .payload_word (payload_word),
    .item         (front_item),
    .track_clear  (track_clear)
  );

  h2ft_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .full      (full),
    .pop       (mid_pop),
    .pop_data  (mid_item),
    .empty     (mid_empty)
  );

  h2ft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .track_clear (track_clear),
    .in_empty    (mid_empty),
    .in_item     (mid_item),
    .in_pop      (mid_pop),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_result  (back_result)
  );

  h2ft_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (back_result),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (head_result),
    .empty     (empty)
  );

  assign verdict          = head_result.verdict;
  assign ping_ack_needed  = head_result.ping_ack_needed;
  assign window_credit    = head_result.window_credit;
  assign fragment_append  = head_result.fragment_append;
  assign block_complete   = head_result.block_complete;
  assign block_is_trailer = head_result.block_is_trailer;
  assign reset_code       = head_result.reset_code;
  assign send_window      = head_result.send_window;

endmodule
